// File: design/irs_pkg.sv
package irs_pkg;

    localparam int MAX_DEVICES = 8;
    localparam int IDX_W       = $clog2(MAX_DEVICES);
    localparam int CNT_W       = $clog2(MAX_DEVICES + 1);
    localparam int ADDR_W      = 32;

    localparam logic [2:0] OP_APPEND   = 3'd0;
    localparam logic [2:0] OP_SET_ADDR = 3'd1;
    localparam logic [2:0] OP_SET_LINK = 3'd2;
    localparam logic [2:0] OP_ROUTE    = 3'd3;
    localparam logic [2:0] OP_FIND     = 3'd4;

    localparam logic [1:0] ST_OK             = 2'd0;
    localparam logic [1:0] ST_FULL           = 2'd1;
    localparam logic [1:0] ST_NOT_REGISTERED = 2'd2;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [IDX_W-1:0]  device_index;
        logic [ADDR_W-1:0] address_value;
        logic [ADDR_W-1:0] mask_value;
        logic [ADDR_W-1:0] gateway_value;
        logic              link_value;
    } irs_item_t;

    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  result_index;
        logic [1:0]        status;
        logic [CNT_W-1:0]  entry_count;
    } irs_result_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] mask;
        logic              has_gateway;
        logic              link_up;
    } irs_entry_t;

endpackage

// File: design/interface_route_selector.sv
// Interface route selector: a table of up to eight interfaces with address, netmask,
// gateway flag and link flag, driven by one command beat per item.
// Input channel s_axis: tuser carries the opcode (append, set addresses, set link,
// route lookup, find by address); tdata carries index, address, mask, gateway, link.
// Output channel m_axis: one result beat per command; tuser is the found flag,
// tdata holds result index, status and the entry count after the command.
// Flow: append and unknown opcodes go from accept straight to the result register,
// set addresses / set link read, merge and write back one memory entry, and
// route lookup and find scan the N registered entries, so at most eight of them.
// The scan is bound by the single read port of the entry memory, one entry a cycle,
// with each entry judged in the cycle after its read while the next read is issued.
// One command is worked on at a time; s_axis_tready is high only while the engine
// is idle. A finished result sits in the output register, so the next command is
// accepted and worked on while m_axis is stalled; that command then waits for the
// register to drain. Reset empties the table (entry count zero); memory contents
// need no clearing since every entry is zeroed when appended.
module interface_route_selector (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // device_index[2:0], address_value[34:3], mask_value[66:35],
    // gateway_value[98:67], link_value[99], zero fill [103:100]
    input  logic [103:0] s_axis_tdata,
    // opcode[2:0]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_index[2:0], status[4:3], entry_count[8:5], zero fill [15:9]
    output logic [15:0]  m_axis_tdata,
    // found[0]
    output logic [0:0]   m_axis_tuser
);
    import irs_pkg::*;

    irs_item_t   in_item;
    irs_result_t eng_result;
    irs_result_t out_res_reg;
    logic        eng_valid;
    logic        res_take;
    logic        out_valid_reg;

    assign in_item.opcode        = s_axis_tuser;
    assign in_item.device_index  = s_axis_tdata[2:0];
    assign in_item.address_value = s_axis_tdata[34:3];
    assign in_item.mask_value    = s_axis_tdata[66:35];
    assign in_item.gateway_value = s_axis_tdata[98:67];
    assign in_item.link_value    = s_axis_tdata[99];

    irs_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .res_valid (eng_valid),
        .res_take  (res_take),
        .result    (eng_result)
    );

    // load the output register when it is empty or draining this cycle
    assign res_take = eng_valid && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_res_reg <= eng_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.found;
    assign m_axis_tdata  = {7'd0, out_res_reg.entry_count, out_res_reg.status,
                            out_res_reg.result_index};

endmodule

// File: design/irs_entry_ram.sv
module irs_entry_ram #(
    parameter int DATA_W = 66,
    parameter int ADDR_W = 3
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/irs_engine.sv
module irs_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  irs_pkg::irs_item_t   in_item,
    output logic                 res_valid,
    input  logic                 res_take,
    output irs_pkg::irs_result_t result
);
    import irs_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RMW  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [2:0]        op_reg, op_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [ADDR_W-1:0] key_reg, key_next;
    logic [ADDR_W-1:0] mask_reg, mask_next;
    logic              gw_reg, gw_next;
    logic              link_reg, link_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic              gw_have_reg, gw_have_next;
    logic [IDX_W-1:0]  gw_pick_reg, gw_pick_next;
    irs_result_t       res_reg, res_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    irs_entry_t        ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    irs_entry_t        ent;
    logic              route_hit;
    logic              find_hit;
    logic              hit;

    irs_entry_ram #(
        .DATA_W ($bits(irs_entry_t)),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ent)
    );

    assign route_hit = ent.link_up && ((key_reg & ent.mask) == (ent.address & ent.mask));
    assign find_hit  = (ent.address == key_reg);
    assign hit       = pend_reg && ((op_reg == OP_ROUTE) ? route_hit : find_hit);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign result    = res_reg;

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        idx_next      = idx_reg;
        key_next      = key_reg;
        mask_next     = mask_reg;
        gw_next       = gw_reg;
        link_next     = link_reg;
        total_next    = total_reg;
        scan_next     = scan_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        gw_have_next  = gw_have_reg;
        gw_pick_next  = gw_pick_reg;
        res_next      = res_reg;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg;
        ram_wdata     = ent;
        ram_raddr     = scan_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next              = in_item.opcode;
                    idx_next             = in_item.device_index;
                    key_next             = in_item.address_value;
                    mask_next            = in_item.mask_value;
                    gw_next              = (in_item.gateway_value != '0);
                    link_next            = in_item.link_value;
                    res_next             = '0;
                    res_next.entry_count = total_reg;
                    state_next           = S_DONE;
                    unique case (in_item.opcode) inside
                        OP_APPEND:
                        begin
                            if (total_reg == CNT_W'(MAX_DEVICES))
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                // new entry starts cleared
                                ram_we                = 1'b1;
                                ram_waddr             = total_reg[IDX_W-1:0];
                                ram_wdata             = '0;
                                res_next.result_index = total_reg[IDX_W-1:0];
                                total_next            = total_reg + 1'b1;
                                res_next.entry_count  = total_reg + 1'b1;
                            end
                        end
                        OP_SET_ADDR, OP_SET_LINK:
                        begin
                            res_next.result_index = in_item.device_index;
                            if (CNT_W'(in_item.device_index) >= total_reg)
                            begin
                                res_next.status = ST_NOT_REGISTERED;
                            end
                            else
                            begin
                                ram_raddr  = in_item.device_index;
                                state_next = S_RMW;
                            end
                        end
                        OP_ROUTE, OP_FIND:
                        begin
                            scan_next    = '0;
                            pend_next    = 1'b0;
                            gw_have_next = 1'b0;
                            gw_pick_next = '0;
                            state_next   = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_RMW:
            begin
                // merge into the entry read last cycle, keep the other fields
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ent;
                if (op_reg == OP_SET_ADDR)
                begin
                    ram_wdata.address     = key_reg;
                    ram_wdata.mask        = mask_reg;
                    ram_wdata.has_gateway = gw_reg;
                end
                else
                begin
                    ram_wdata.link_up = link_reg;
                end
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    res_next.found        = 1'b1;
                    res_next.result_index = pend_idx_reg;
                    state_next            = S_DONE;
                end
                else
                begin
                    if (pend_reg && (op_reg == OP_ROUTE) && ent.link_up && ent.has_gateway)
                    begin
                        gw_have_next = 1'b1;
                        gw_pick_next = pend_idx_reg;
                    end
                    // issue the next read while the previous entry is judged
                    if (scan_reg < total_reg)
                    begin
                        ram_raddr     = scan_reg[IDX_W-1:0];
                        pend_next     = 1'b1;
                        pend_idx_next = scan_reg[IDX_W-1:0];
                        scan_next     = scan_reg + 1'b1;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                        if (!pend_reg)
                        begin
                            if (op_reg == OP_ROUTE)
                            begin
                                if (gw_have_reg)
                                begin
                                    res_next.found        = 1'b1;
                                    res_next.result_index = gw_pick_reg;
                                end
                                else if (total_reg != '0)
                                begin
                                    res_next.found        = 1'b1;
                                    res_next.result_index = '0;
                                end
                            end
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            total_reg   <= '0;
            scan_reg    <= '0;
            pend_reg    <= 1'b0;
            gw_have_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            scan_reg    <= scan_next;
            pend_reg    <= pend_next;
            gw_have_reg <= gw_have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        key_reg      <= key_next;
        mask_reg     <= mask_next;
        gw_reg       <= gw_next;
        link_reg     <= link_next;
        pend_idx_reg <= pend_idx_next;
        gw_pick_reg  <= gw_pick_next;
        res_reg      <= res_next;
    end

endmodule

// File: verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import irs_pkg::*;

    // opcodes the block does not decode
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int RANDOM_COMMANDS = 1875;
    localparam int QUIET_TAIL      = 250;
    localparam int STALL_LIMIT     = 2000;
    localparam int MAX_REPORTS     = 10;

    typedef struct {
        irs_item_t   cmd;
        bit          fixed;
        irs_result_t answer;
    } command_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;
    logic [2:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [15:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    // shadow of the interface table
    logic [ADDR_W-1:0] shadow_addr [MAX_DEVICES];
    logic [ADDR_W-1:0] shadow_mask [MAX_DEVICES];
    logic              shadow_gw   [MAX_DEVICES];
    logic              shadow_up   [MAX_DEVICES];
    int                shadow_count;

    irs_result_t  pending_results [$];
    command_row_t directed_rows [$];

    bit          row_fixed;
    irs_result_t row_answer;
    bit          idle_on;

    int mismatches;
    int results_checked;
    int commands_sent;
    int route_count;
    int find_count;
    int quiet_cycles;

    interface_route_selector uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Advance the shadow table by one command and return the result it must give.
    function automatic irs_result_t apply_command(input irs_item_t c);
        irs_result_t      r;
        logic             hit;
        logic             gw_seen;
        logic [IDX_W-1:0] gw_idx;
        int               i;
        r       = '0;
        hit     = 1'b0;
        gw_seen = 1'b0;
        gw_idx  = '0;
        case (c.opcode)
            OP_APPEND:
            begin
                if (shadow_count >= MAX_DEVICES)
                    r.status = ST_FULL;
                else
                begin
                    shadow_addr[shadow_count] = '0;
                    shadow_mask[shadow_count] = '0;
                    shadow_gw[shadow_count]   = 1'b0;
                    shadow_up[shadow_count]   = 1'b0;
                    r.result_index = IDX_W'(shadow_count);
                    shadow_count++;
                end
            end
            OP_SET_ADDR:
            begin
                r.result_index = c.device_index;
                if (c.device_index >= shadow_count)
                    r.status = ST_NOT_REGISTERED;
                else
                begin
                    shadow_addr[c.device_index] = c.address_value;
                    shadow_mask[c.device_index] = c.mask_value;
                    shadow_gw[c.device_index]   = (c.gateway_value != '0);
                end
            end
            OP_SET_LINK:
            begin
                r.result_index = c.device_index;
                if (c.device_index >= shadow_count)
                    r.status = ST_NOT_REGISTERED;
                else
                    shadow_up[c.device_index] = c.link_value;
            end
            OP_ROUTE:
            begin
                // stop at the first subnet hit; gateways only count before it
                for (i = 0; i < shadow_count; i++)
                begin
                    if (!hit && shadow_up[i])
                    begin
                        if ((c.address_value & shadow_mask[i]) ==
                            (shadow_addr[i] & shadow_mask[i]))
                        begin
                            hit            = 1'b1;
                            r.result_index = IDX_W'(i);
                        end
                        else if (shadow_gw[i])
                        begin
                            gw_seen = 1'b1;
                            gw_idx  = IDX_W'(i);
                        end
                    end
                end
                if (hit)
                    r.found = 1'b1;
                else if (gw_seen)
                begin
                    r.found        = 1'b1;
                    r.result_index = gw_idx;
                end
                else if (shadow_count > 0)
                    r.found = 1'b1;
            end
            OP_FIND:
            begin
                for (i = 0; i < shadow_count; i++)
                begin
                    if (!hit && shadow_addr[i] == c.address_value)
                    begin
                        hit            = 1'b1;
                        r.found        = 1'b1;
                        r.result_index = IDX_W'(i);
                    end
                end
            end
            default: ;
        endcase
        r.entry_count = CNT_W'(shadow_count);
        return r;
    endfunction

    function automatic command_row_t make_row(input logic [2:0] op,
                                              input logic [IDX_W-1:0] idx,
                                              input logic [ADDR_W-1:0] addr,
                                              input logic [ADDR_W-1:0] mask,
                                              input logic [ADDR_W-1:0] gw,
                                              input logic link,
                                              input bit fixed,
                                              input logic found,
                                              input logic [IDX_W-1:0] ridx,
                                              input logic [1:0] st,
                                              input logic [CNT_W-1:0] cnt);
        command_row_t row;
        row.cmd.opcode              = op;
        row.cmd.device_index        = idx;
        row.cmd.address_value       = addr;
        row.cmd.mask_value          = mask;
        row.cmd.gateway_value       = gw;
        row.cmd.link_value          = link;
        row.fixed                   = fixed;
        row.answer.found            = found;
        row.answer.result_index     = ridx;
        row.answer.status           = st;
        row.answer.entry_count      = cnt;
        return row;
    endfunction

    // Mostly commands aimed at the current table contents, some pure noise.
    function automatic irs_item_t random_command();
        irs_item_t c;
        int        pick;
        int        k;
        int        plen;
        c.opcode        = OP_ROUTE;
        c.device_index  = IDX_W'($urandom_range(0, MAX_DEVICES - 1));
        c.address_value = $urandom;
        c.mask_value    = $urandom;
        c.gateway_value = $urandom;
        c.link_value    = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        k    = (shadow_count > 0) ? $urandom_range(0, shadow_count - 1) : 0;
        if (pick < 3)
            c.opcode = OP_APPEND;
        else if (pick < 6)
            c.opcode = OP_SPARE_5 + 3'($urandom_range(0, 2));
        else if (pick < 26)
        begin
            c.opcode = OP_SET_ADDR;
            if ($urandom_range(0, 3) != 0)
            begin
                plen = $urandom_range(0, ADDR_W);
                c.mask_value = (plen == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - plen));
            end
            if ($urandom_range(0, 1) != 0)
                c.gateway_value = '0;
            if ($urandom_range(0, 7) == 0)
                c.address_value = shadow_addr[k];
        end
        else if (pick < 46)
            c.opcode = OP_SET_LINK;
        else if (pick < 82)
        begin
            c.opcode = OP_ROUTE;
            if (shadow_count > 0 && $urandom_range(0, 2) != 0)
                c.address_value = shadow_addr[k] ^ ($urandom & ~shadow_mask[k]);
        end
        else
        begin
            c.opcode = OP_FIND;
            if (shadow_count > 0 && $urandom_range(0, 1) != 0)
                c.address_value = shadow_addr[k];
        end
        return c;
    endfunction

    // Called at a falling edge; hold the beat until it is taken.
    task automatic drive_beat(input irs_item_t c, input bit fixed, input irs_result_t ans);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = c.opcode;
        s_axis_tdata  = {4'b0, c.link_value, c.gateway_value, c.mask_value,
                         c.address_value, c.device_index};
        row_fixed     = fixed;
        row_answer    = ans;
        do
            @(posedge clk);
        while (!s_axis_tready);
        commands_sent++;
    endtask

    task automatic sender_gap();
        int n;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 14);
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic note_mismatch(input irs_result_t want, input irs_result_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display({"MISMATCH result %0d: found %0d/%0d index %0d/%0d ",
                      "status %0d/%0d count %0d/%0d (exp/act)"},
                     results_checked, want.found, got.found, want.result_index,
                     got.result_index, want.status, got.status,
                     want.entry_count, got.entry_count);
    endtask

    // Predict on each accepted command beat, check each result beat.
    always @(posedge clk)
    begin
        irs_item_t   seen;
        irs_result_t predicted;
        irs_result_t got;
        irs_result_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                seen.opcode        = s_axis_tuser;
                seen.device_index  = s_axis_tdata[2:0];
                seen.address_value = s_axis_tdata[34:3];
                seen.mask_value    = s_axis_tdata[66:35];
                seen.gateway_value = s_axis_tdata[98:67];
                seen.link_value    = s_axis_tdata[99];
                if (seen.opcode == OP_ROUTE)
                    route_count++;
                if (seen.opcode == OP_FIND)
                    find_count++;
                predicted = apply_command(seen);
                pending_results.push_back(row_fixed ? row_answer : predicted);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.found        = m_axis_tuser[0];
                got.result_index = m_axis_tdata[2:0];
                got.status       = m_axis_tdata[4:3];
                got.entry_count  = m_axis_tdata[8:5];
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("MISMATCH: result beat with nothing outstanding (tdata %h)",
                                 m_axis_tdata);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.found !== want.found || got.result_index !== want.result_index ||
                        got.status !== want.status || got.entry_count !== want.entry_count)
                        note_mismatch(want, got);
                    results_checked++;
                end
            end
        end
    end

    // Watchdog: cycles with no beat on either side.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side back-pressure in bursts.
    initial
    begin
        int n;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 14);
                m_axis_tready = 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    initial
    begin
        irs_item_t   c;
        irs_result_t none;
        int          i;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_APPEND;
        row_fixed     = 1'b0;
        row_answer    = '0;
        idle_on       = 1'b1;
        mismatches    = 0;
        results_checked = 0;
        commands_sent = 0;
        route_count   = 0;
        find_count    = 0;
        quiet_cycles  = 0;
        shadow_count  = 0;
        none          = '0;
        for (i = 0; i < MAX_DEVICES; i++)
        begin
            shadow_addr[i] = '0;
            shadow_mask[i] = '0;
            shadow_gw[i]   = 1'b0;
            shadow_up[i]   = 1'b0;
        end

        // empty table
        directed_rows.push_back(make_row(OP_ROUTE, 0, 32'h1234_5678, 0, 0, 0, 1, 0, 0, ST_OK, 0));
        directed_rows.push_back(make_row(OP_FIND, 0, 32'h0, 0, 0, 0, 1, 0, 0, ST_OK, 0));
        directed_rows.push_back(make_row(OP_SET_ADDR, 0, 32'h0A00_0001, 32'hFFFF_FF00, 1, 0,
                                         1, 0, 0, ST_NOT_REGISTERED, 0));
        directed_rows.push_back(make_row(OP_SET_LINK, 7, 0, 0, 0, 1, 1, 0, 7,
                                         ST_NOT_REGISTERED, 0));
        // one entry, link down: fall back to entry 0
        directed_rows.push_back(make_row(OP_APPEND, 0, 0, 0, 0, 0, 1, 0, 0, ST_OK, 1));
        directed_rows.push_back(make_row(OP_ROUTE, 0, 32'h1234_5678, 0, 0, 0, 1, 1, 0, ST_OK, 1));
        directed_rows.push_back(make_row(OP_APPEND, 0, 0, 0, 0, 0, 1, 0, 1, ST_OK, 2));
        directed_rows.push_back(make_row(OP_SET_ADDR, 1, 32'hC0A8_0101, 32'hFFFF_0000, 0, 0,
                                         0, 0, 0, ST_OK, 0));
        directed_rows.push_back(make_row(OP_SET_LINK, 1, 0, 0, 0, 1, 0, 0, 0, ST_OK, 0));
        // same link state again
        directed_rows.push_back(make_row(OP_SET_LINK, 1, 0, 0, 0, 1, 0, 0, 0, ST_OK, 0));
        // index just past the table
        directed_rows.push_back(make_row(OP_SET_ADDR, 2, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                         32'hFFFF_FFFF, 1, 1, 0, 2, ST_NOT_REGISTERED, 2));
        directed_rows.push_back(make_row(OP_ROUTE, 0, 32'hC0A8_FFFF, 0, 0, 0, 0, 0, 0, ST_OK, 0));
        // find ignores the link state
        directed_rows.push_back(make_row(OP_FIND, 0, 32'h0, 0, 0, 0, 0, 0, 0, ST_OK, 0));
        for (i = 2; i < MAX_DEVICES; i++)
            directed_rows.push_back(make_row(OP_APPEND, 0, 0, 0, 0, 0, 1, 0, IDX_W'(i), ST_OK,
                                             CNT_W'(i + 1)));
        directed_rows.push_back(make_row(OP_APPEND, 0, 0, 0, 0, 0, 1, 0, 0, ST_FULL, 8));
        directed_rows.push_back(make_row(OP_SET_ADDR, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                         32'hFFFF_FFFF, 1, 0, 0, 0, ST_OK, 0));
        directed_rows.push_back(make_row(OP_SET_LINK, 7, 0, 0, 0, 1, 0, 0, 0, ST_OK, 0));
        // no subnet hit: last gateway entry wins
        directed_rows.push_back(make_row(OP_ROUTE, 0, 32'h0102_0304, 0, 0, 0, 0, 0, 0, ST_OK, 0));
        directed_rows.push_back(make_row(OP_FIND, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, ST_OK, 0));
        directed_rows.push_back(make_row(OP_SPARE_5, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                         32'hFFFF_FFFF, 1, 1, 0, 0, ST_OK, 8));
        directed_rows.push_back(make_row(OP_SPARE_6, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                         32'hFFFF_FFFF, 1, 1, 0, 0, ST_OK, 8));
        directed_rows.push_back(make_row(OP_SPARE_7, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                         32'hFFFF_FFFF, 1, 1, 0, 0, ST_OK, 8));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[r])
        begin
            sender_gap();
            @(negedge clk);
            drive_beat(directed_rows[r].cmd, directed_rows[r].fixed, directed_rows[r].answer);
        end

        for (i = 0; i < RANDOM_COMMANDS; i++)
        begin
            if (i >= RANDOM_COMMANDS - QUIET_TAIL)
                idle_on = 1'b0;
            else if (i % 150 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            sender_gap();
            // drain everything once mid-run
            if (i == RANDOM_COMMANDS / 2)
            begin
                @(negedge clk);
                s_axis_tvalid = 1'b0;
                while (pending_results.size() != 0)
                    @(negedge clk);
            end
            @(negedge clk);
            c = random_command();
            drive_beat(c, 1'b0, none);
        end
        @(negedge clk);
        s_axis_tvalid = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (pending_results.size() != 0)
            mismatches++;
        $display("Covered %0d commands (%0d route lookups, %0d finds) with bursty idling",
                 commands_sent, route_count, find_count);
        $display("on both sides; %0d results checked, %0d mismatches", results_checked,
                 mismatches);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
